[rtl/ecn_fraction_window_estimator_macros.svh]
// Assertion macros used by the estimator back end.
`ifndef ECN_FRACTION_WINDOW_ESTIMATOR_MACROS_SVH
`define ECN_FRACTION_WINDOW_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ECNFW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ECNFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ecnfw_pkg.sv]
// Package: types, constants and sequence helpers for the ECN fraction estimator.
package ecnfw_pkg;

  localparam int SEQ_W       = 32;
  localparam int ALPHA_W     = 17;
  localparam int SEG_W       = 16;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int S_DATA_W    = 216;
  localparam int S_USER_W    = 2;
  localparam int M_DATA_W    = 88;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int RATIO_STEPS = 16;
  localparam int STEP_CNT_W  = $clog2(RATIO_STEPS);

  localparam logic [ALPHA_W-1:0] Q16_ONE            = 17'd65536;
  localparam logic [ALPHA_W-1:0] EWMA_WEIGHT_RESET  = 17'd4096;
  localparam logic [SEG_W-1:0]   SEGMENT_SIZE_RESET = 16'd536;
  localparam logic [17:0]        Q17_ONE            = 18'd131072;

  localparam logic [CFG_INDEX_W-1:0] REG_EWMA_WEIGHT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_SIZE = 1'b1;

  typedef enum logic [1:0] {
    MODE_ACK     = 2'd0,
    MODE_SEND    = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_CUT     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_BLEND,
    ST_ALPHA,
    ST_CUT,
    ST_OUT
  } state_t;

  // Classified event. ACK: a = ack number, b = newly acked bytes.
  // SEND: a = later of segment end and tx mark. TIMEOUT: a = head. CUT: a = window.
  typedef struct packed {
    mode_t            mode;
    logic             ece;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
  } cmd_t;

  function automatic logic seq_after(input logic [SEQ_W-1:0] x, input logic [SEQ_W-1:0] y);
    logic [SEQ_W-1:0] d;
    d = x - y;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_max(input logic [SEQ_W-1:0] x,
                                              input logic [SEQ_W-1:0] y);
    return seq_after(y, x) ? y : x;
  endfunction

endpackage

[rtl/ecnfw_front.sv]
// Front end: accepts input transactions and classifies them into queue commands.
module ecnfw_front import ecnfw_pkg::*; (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: ack_number, ece_flag, highest_acked, seq_start, seg_len,
  //        high_tx_mark, head_seq, window_bytes, zero pad
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // tuser: mode
  input  logic [S_USER_W-1:0] s_axis_tuser,
  input  logic                queue_full,
  output logic                push,
  output cmd_t                cmd
);

  mode_t            mode;
  logic [SEQ_W-1:0] ack_number;
  logic             ece_flag;
  logic [SEQ_W-1:0] highest_acked;
  logic [SEQ_W-1:0] seq_start;
  logic [SEG_W-1:0] seg_len;
  logic [SEQ_W-1:0] high_tx_mark;
  logic [SEQ_W-1:0] head_seq;
  logic [SEQ_W-1:0] window_bytes;
  logic [SEQ_W-1:0] acked;
  logic             acked_ok;
  logic [SEQ_W-1:0] send_end;

  assign mode          = mode_t'(s_axis_tuser);
  assign ack_number    = s_axis_tdata[31:0];
  assign ece_flag      = s_axis_tdata[32];
  assign highest_acked = s_axis_tdata[64:33];
  assign seq_start     = s_axis_tdata[96:65];
  assign seg_len       = s_axis_tdata[112:97];
  assign high_tx_mark  = s_axis_tdata[144:113];
  assign head_seq      = s_axis_tdata[176:145];
  assign window_bytes  = s_axis_tdata[208:177];

  assign acked    = ack_number - highest_acked;
  assign acked_ok = (acked != '0) && !acked[SEQ_W-1];
  assign send_end = seq_start + {{(SEQ_W-SEG_W){1'b0}}, seg_len};

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  always_comb begin
    cmd.mode = mode;
    cmd.ece  = 1'b0;
    cmd.a    = '0;
    cmd.b    = '0;
    unique case (mode)
      MODE_ACK: begin
        cmd.ece = ece_flag;
        cmd.a   = ack_number;
        cmd.b   = acked_ok ? acked : '0;
      end
      MODE_SEND:    cmd.a = seq_max(send_end, high_tx_mark);
      MODE_TIMEOUT: cmd.a = head_seq;
      MODE_CUT:     cmd.a = window_bytes;
      default:      cmd.a = '0;
    endcase
  end

endmodule

[rtl/ecnfw_fifo.sv]
// Command queue between front end and back end.
module ecnfw_fifo import ecnfw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/ecnfw_back.sv]
// Back end: estimator state, ratio divider, EWMA blend, window cut and output register.
`include "ecn_fraction_window_estimator_macros.svh"
module ecnfw_back import ecnfw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 queue_empty,
  input  cmd_t                 queue_dout,
  output logic                 pop,
  input  logic [ALPHA_W-1:0]   ewma_weight,
  input  logic [SEG_W-1:0]     segment_size,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: alpha_now, alpha_updated, new_ssthresh, new_cwnd, zero pad
  output logic [M_DATA_W-1:0]  m_axis_tdata
);

  state_t state, state_next;

  cmd_t                  cmd_q;
  logic [ALPHA_W-1:0]    alpha;
  logic [SEQ_W-1:0]      marked_bytes;
  logic [SEQ_W-1:0]      total_bytes;
  logic [SEQ_W-1:0]      update_mark;
  logic [SEQ_W-1:0]      max_sent_seq;
  logic [SEQ_W-1:0]      div_den;
  logic [SEQ_W-1:0]      div_rem;
  logic [ALPHA_W-1:0]    quot;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [33:0]           blend_p1;
  logic [33:0]           blend_p2;
  logic [SEQ_W-1:0]      cut_v;
  logic                  res_updated;
  logic [SEQ_W-1:0]      res_ssth;
  logic [SEQ_W-1:0]      res_cwnd;
  logic [ALPHA_W-1:0]    out_alpha;
  logic                  out_updated;
  logic [SEQ_W-1:0]      out_ssth;
  logic [SEQ_W-1:0]      out_cwnd;

  logic                  out_free;
  logic                  out_load;
  logic [SEQ_W:0]        total_sum;
  logic [SEQ_W:0]        marked_sum;
  logic [SEQ_W-1:0]      total_new;
  logic [SEQ_W-1:0]      marked_new;
  logic [SEQ_W-1:0]      den_new;
  logic                  ratio_sat;
  logic                  ack_after;
  logic [SEQ_W:0]        rem2;
  logic                  div_ge;
  logic [SEQ_W:0]        rem_sub;
  logic [ALPHA_W-1:0]    g_eff;
  logic [ALPHA_W-1:0]    g_inv;
  logic [34:0]           blend_sum;
  logic [18:0]           alpha_blend;
  logic [ALPHA_W-1:0]    alpha_new;
  logic [17:0]           alpha_comp;
  logic [49:0]           cut_prod;
  logic [SEQ_W-1:0]      floor2;
  logic [SEQ_W-1:0]      floor1;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign total_sum  = {1'b0, total_bytes} + {1'b0, cmd_q.b};
  assign marked_sum = {1'b0, marked_bytes} + {1'b0, cmd_q.b};
  assign total_new  = total_sum[SEQ_W] ? '1 : total_sum[SEQ_W-1:0];
  assign marked_new = !cmd_q.ece ? marked_bytes :
                      (marked_sum[SEQ_W] ? '1 : marked_sum[SEQ_W-1:0]);
  assign den_new    = (total_new == '0) ? 32'd1 : total_new;
  assign ratio_sat  = (marked_new >= den_new);
  assign ack_after  = seq_after(cmd_q.a, update_mark);

  // One quotient bit per cycle; remainder always below divisor.
  assign rem2    = {div_rem, 1'b0};
  assign div_ge  = (rem2 >= {1'b0, div_den});
  assign rem_sub = rem2 - {1'b0, div_den};

  assign g_eff       = (ewma_weight > Q16_ONE) ? Q16_ONE : ewma_weight;
  assign g_inv       = Q16_ONE - g_eff;
  assign blend_sum   = {1'b0, blend_p1} + {1'b0, blend_p2} + 35'd32768;
  assign alpha_blend = blend_sum[34:16];
  assign alpha_new   = (alpha_blend > 19'(Q16_ONE)) ? Q16_ONE : alpha_blend[ALPHA_W-1:0];

  assign alpha_comp = Q17_ONE - {1'b0, alpha};
  assign cut_prod   = cmd_q.a * alpha_comp;
  assign floor2     = {{(SEQ_W-SEG_W-1){1'b0}}, segment_size, 1'b0};
  assign floor1     = {{(SEQ_W-SEG_W){1'b0}}, segment_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!queue_empty) begin
          pop        = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_q.mode)
          MODE_ACK: begin
            if (!ack_after) begin
              state_next = ST_OUT;
            end else if (ratio_sat) begin
              state_next = ST_BLEND;
            end else begin
              state_next = ST_DIV;
            end
          end
          MODE_CUT: state_next = ST_CUT;
          default:  state_next = ST_OUT;
        endcase
      end
      ST_DIV: begin
        if (step_cnt == STEP_CNT_W'(RATIO_STEPS - 1)) begin
          state_next = ST_BLEND;
        end
      end
      ST_BLEND: state_next = ST_ALPHA;
      ST_ALPHA: state_next = ST_OUT;
      ST_CUT:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha         <= Q16_ONE;
      marked_bytes  <= '0;
      total_bytes   <= '0;
      update_mark   <= '0;
      max_sent_seq  <= '0;
      step_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            cmd_q <= queue_dout;
          end
        end
        ST_EXEC: begin
          res_updated <= 1'b0;
          res_ssth    <= '0;
          res_cwnd    <= '0;
          case (cmd_q.mode)
            MODE_ACK: begin
              total_bytes  <= total_new;
              marked_bytes <= marked_new;
              div_den      <= den_new;
              div_rem      <= marked_new;
              step_cnt     <= '0;
              quot         <= ratio_sat ? Q16_ONE : '0;
            end
            MODE_SEND: begin
              if (!seq_after(max_sent_seq, cmd_q.a)) begin
                max_sent_seq <= cmd_q.a;
              end
            end
            MODE_TIMEOUT: begin
              update_mark  <= cmd_q.a;
              max_sent_seq <= cmd_q.a;
            end
            default: cut_v <= cut_prod[48:17];
          endcase
        end
        ST_DIV: begin
          div_rem  <= div_ge ? rem_sub[SEQ_W-1:0] : rem2[SEQ_W-1:0];
          quot     <= {quot[ALPHA_W-2:0], div_ge};
          step_cnt <= step_cnt + 1'b1;
        end
        ST_BLEND: begin
          blend_p1 <= alpha * g_inv;
          blend_p2 <= quot * g_eff;
        end
        ST_ALPHA: begin
          alpha        <= alpha_new;
          marked_bytes <= '0;
          total_bytes  <= '0;
          update_mark  <= max_sent_seq;
          res_updated  <= 1'b1;
        end
        ST_CUT: begin
          res_ssth <= (cut_v > floor2) ? cut_v : floor2;
          res_cwnd <= (cut_v > floor1) ? cut_v : floor1;
        end
        default: begin
          if (out_load) begin
            out_alpha   <= alpha;
            out_updated <= res_updated;
            out_ssth    <= res_ssth;
            out_cwnd    <= res_cwnd;
          end
        end
      endcase
    end
  end

  assign m_axis_tdata = {6'b0, out_cwnd, out_ssth, out_updated, out_alpha};

  `ECNFW_ASSERT_NOW(a_marked_le_total, 1'b1, marked_bytes <= total_bytes, "marked exceeds total")
  `ECNFW_ASSERT_NOW(a_alpha_range, 1'b1, alpha <= Q16_ONE, "alpha above one")
  `ECNFW_ASSERT_NOW(a_div_rem, state == ST_DIV, div_rem < div_den, "divider remainder too large")
  `ECNFW_ASSERT_NEXT(a_out_load, state == ST_OUT && out_free, m_axis_tvalid && state == ST_IDLE, "result not presented")

endmodule

[rtl/ecn_fraction_window_estimator.sv]
// Top level of the ECN fraction window estimator: config registers, front end, queue, back end.
// The back end takes one command at a time: a send, timeout or non-updating ACK passes EXEC
//   and OUT; a window cut adds CUT; an alpha update adds the bit-serial ratio divider (DIV),
//   BLEND and ALPHA, and skips the divider when marked equals total. OUT waits for the output.
// The front end accepts while the command queue has room, independent of the output stall.
// Reset (synchronous): alpha 1.0, byte counters and sequence marks zero, gain 4096, segment 536,
//   queue and output empty; no clearing pass.
module ecn_fraction_window_estimator import ecnfw_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: ack_number, ece_flag, highest_acked, seq_start, seg_len,
  //        high_tx_mark, head_seq, window_bytes, zero pad
  input  logic [S_DATA_W-1:0]    s_axis_tdata,
  // tuser: mode
  input  logic [S_USER_W-1:0]    s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: alpha_now, alpha_updated, new_ssthresh, new_cwnd, zero pad
  output logic [M_DATA_W-1:0]    m_axis_tdata
);

  logic [ALPHA_W-1:0] ewma_weight;
  logic [SEG_W-1:0]   segment_size;
  logic               push;
  logic               pop;
  logic               queue_full;
  logic               queue_empty;
  cmd_t               queue_din;
  cmd_t               queue_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_weight  <= EWMA_WEIGHT_RESET;
      segment_size <= SEGMENT_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EWMA_WEIGHT:  ewma_weight  <= cfg_data;
        REG_SEGMENT_SIZE: segment_size <= cfg_data[SEG_W-1:0];
        default:          ewma_weight  <= ewma_weight;
      endcase
    end
  end

  ecnfw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .push          (push),
    .cmd           (queue_din)
  );

  ecnfw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (queue_din),
    .full  (queue_full),
    .pop   (pop),
    .dout  (queue_dout),
    .empty (queue_empty)
  );

  ecnfw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .queue_dout    (queue_dout),
    .pop           (pop),
    .ewma_weight   (ewma_weight),
    .segment_size  (segment_size),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[sim/tb_ecn_fraction_window_estimator.sv]
// Self-checking testbench for the ECN fraction window estimator: stream driver, monitor, predictor.
module tb_ecn_fraction_window_estimator;
  import ecnfw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    mode_t       mode;
    logic [31:0] ack_number;
    logic        ece_flag;
    logic [31:0] highest_acked;
    logic [31:0] seq_start;
    logic [15:0] seg_len;
    logic [31:0] high_tx_mark;
    logic [31:0] head_seq;
    logic [31:0] window_bytes;
  } tcp_item_t;

  typedef struct {
    logic [16:0] alpha_now;
    logic        alpha_updated;
    logic [31:0] new_ssthresh;
    logic [31:0] new_cwnd;
  } estimate_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_EWMA_WEIGHT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_DATA_W-1:0]    s_axis_tdata = '0;
  logic [S_USER_W-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]    m_axis_tdata;

  ecn_fraction_window_estimator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tcp_item_t pending_items[$];
  estimate_t expected_estimates[$];
  tcp_item_t item_on_bus;
  int        err_count = 0;
  int        cycle_count = 0;

  // predictor state and register copies
  logic [16:0] gain_reg = EWMA_WEIGHT_RESET;
  logic [15:0] mss_reg = SEGMENT_SIZE_RESET;
  logic [16:0] alpha_q = Q16_ONE;
  logic [31:0] marked_cnt = '0;
  logic [31:0] total_cnt = '0;
  logic [31:0] recalc_mark = '0;
  logic [31:0] snd_max = '0;

  // stimulus-side connection view
  logic [31:0] snd_nxt;
  logic [31:0] snd_una;

  function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d >= 32'd1 && d <= 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] later_of(input logic [31:0] a, input logic [31:0] b);
    return is_later(b, a) ? b : a;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic estimate_t predict_estimate(input tcp_item_t it);
    estimate_t   r;
    logic [31:0] acked;
    logic [31:0] vr;
    logic [31:0] floor2;
    logic [63:0] den;
    logic [63:0] ratio;
    logic [63:0] g;
    logic [63:0] acc;
    logic [63:0] v;
    r = '{alpha_now: '0, alpha_updated: 1'b0, new_ssthresh: '0, new_cwnd: '0};
    case (it.mode)
      MODE_ACK: begin
        acked = it.ack_number - it.highest_acked;
        if (acked != 0 && !acked[31]) begin
          total_cnt = add_sat(total_cnt, acked);
          if (it.ece_flag) marked_cnt = add_sat(marked_cnt, acked);
        end
        if (is_later(it.ack_number, recalc_mark)) begin
          den = (total_cnt == 0) ? 64'd1 : 64'(total_cnt);
          ratio = {16'd0, marked_cnt, 16'd0} / den;
          if (ratio > 64'd65536) ratio = 64'd65536;
          g = (gain_reg > 17'd65536) ? 64'd65536 : 64'(gain_reg);
          acc = 64'(alpha_q) * (64'd65536 - g) + ratio * g + 64'd32768;
          acc = acc >> 16;
          alpha_q = (acc > 64'd65536) ? 17'd65536 : acc[16:0];
          recalc_mark = snd_max;
          marked_cnt = '0;
          total_cnt = '0;
          r.alpha_updated = 1'b1;
        end
      end
      MODE_SEND: begin
        snd_max = later_of(later_of(it.seq_start + 32'(it.seg_len), it.high_tx_mark), snd_max);
      end
      MODE_TIMEOUT: begin
        recalc_mark = it.head_seq;
        snd_max = it.head_seq;
      end
      default: begin
        v = (64'(it.window_bytes) * (64'd131072 - 64'(alpha_q))) >> 17;
        vr = v[31:0];
        floor2 = 32'(mss_reg) << 1;
        r.new_ssthresh = (vr > floor2) ? vr : floor2;
        r.new_cwnd = (vr > 32'(mss_reg)) ? vr : 32'(mss_reg);
      end
    endcase
    r.alpha_now = alpha_q;
    return r;
  endfunction

  // ---------------- driver ----------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_estimates.push_back(predict_estimate(item_on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item_on_bus = pending_items.pop_front();
          s_axis_tdata <= {7'd0, item_on_bus.window_bytes, item_on_bus.head_seq,
                           item_on_bus.high_tx_mark, item_on_bus.seg_len, item_on_bus.seq_start,
                           item_on_bus.highest_acked, item_on_bus.ece_flag,
                           item_on_bus.ack_number};
          s_axis_tuser <= item_on_bus.mode;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int        stall_style = 0;
  int        style_left = 0;
  estimate_t got;
  estimate_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 120);
      end else begin
        style_left = style_left - 1;
      end
      case (stall_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= (cycle_count % 6 == 0);
        default: m_axis_tready <= ($urandom_range(0, 9) == 0);
      endcase
      if (m_axis_tvalid && m_axis_tready) begin
        got.alpha_now = m_axis_tdata[16:0];
        got.alpha_updated = m_axis_tdata[17];
        got.new_ssthresh = m_axis_tdata[49:18];
        got.new_cwnd = m_axis_tdata[81:50];
        if (expected_estimates.size() == 0) begin
          $error("unexpected result transaction: %h", m_axis_tdata);
          err_count++;
        end else begin
          want = expected_estimates.pop_front();
          if (got.alpha_now !== want.alpha_now) begin
            $error("alpha_now: expected %0d, got %0d", want.alpha_now, got.alpha_now);
            err_count++;
          end
          if (got.alpha_updated !== want.alpha_updated) begin
            $error("alpha_updated: expected %0d, got %0d", want.alpha_updated,
                   got.alpha_updated);
            err_count++;
          end
          if (got.new_ssthresh !== want.new_ssthresh) begin
            $error("new_ssthresh: expected %0d, got %0d", want.new_ssthresh, got.new_ssthresh);
            err_count++;
          end
          if (got.new_cwnd !== want.new_cwnd) begin
            $error("new_cwnd: expected %0d, got %0d", want.new_cwnd, got.new_cwnd);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic tcp_item_t blank_item(input mode_t m);
    tcp_item_t it;
    it = '{mode: m, ack_number: '0, ece_flag: 1'b0, highest_acked: '0, seq_start: '0,
           seg_len: '0, high_tx_mark: '0, head_seq: '0, window_bytes: '0};
    return it;
  endfunction

  task automatic add_ack(input logic [31:0] ack, input logic [31:0] hi, input logic ece);
    tcp_item_t it;
    it = blank_item(MODE_ACK);
    it.ack_number = ack;
    it.highest_acked = hi;
    it.ece_flag = ece;
    pending_items.push_back(it);
  endtask

  task automatic add_send(input logic [31:0] seq, input logic [15:0] len,
                          input logic [31:0] htx);
    tcp_item_t it;
    it = blank_item(MODE_SEND);
    it.seq_start = seq;
    it.seg_len = len;
    it.high_tx_mark = htx;
    pending_items.push_back(it);
  endtask

  task automatic add_timeout(input logic [31:0] head);
    tcp_item_t it;
    it = blank_item(MODE_TIMEOUT);
    it.head_seq = head;
    pending_items.push_back(it);
  endtask

  task automatic add_cut(input logic [31:0] win);
    tcp_item_t it;
    it = blank_item(MODE_CUT);
    it.window_bytes = win;
    pending_items.push_back(it);
  endtask

  task automatic add_noise();
    tcp_item_t it;
    it.mode = mode_t'(2'($urandom_range(0, 3)));
    it.ack_number = $urandom;
    it.ece_flag = 1'($urandom_range(0, 1));
    it.highest_acked = $urandom;
    it.seq_start = $urandom;
    it.seg_len = 16'($urandom);
    it.high_tx_mark = $urandom;
    it.head_seq = $urandom;
    it.window_bytes = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_EWMA_WEIGHT) gain_reg = val;
    else mss_reg = val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_estimates.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_traffic(input int count);
    logic [31:0] outstanding;
    logic [15:0] len;
    logic [31:0] ack;
    int          pick;
    snd_una = $urandom;
    snd_nxt = snd_una;
    add_timeout(snd_una);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 9))
          0: len = 16'd0;
          1: len = 16'hFFFF;
          default: len = 16'($urandom_range(1, 1460));
        endcase
        add_send(snd_nxt, len, ($urandom_range(0, 3) == 0) ? snd_una : snd_nxt + 32'(len));
        snd_nxt = snd_nxt + 32'(len);
      end else if (pick < 75) begin
        outstanding = snd_nxt - snd_una;
        if (outstanding == 0 || $urandom_range(0, 9) == 0) ack = snd_una;
        else if ($urandom_range(0, 3) == 0) ack = snd_nxt;
        else ack = snd_una + $urandom_range(1, outstanding);
        add_ack(ack, snd_una, $urandom_range(0, 9) < 3);
        snd_una = ack;
      end else if (pick < 80) begin
        add_timeout(snd_una);
        snd_nxt = snd_una;
      end else if (pick < 88) begin
        case ($urandom_range(0, 3))
          0: add_cut($urandom_range(0, 4000));
          1: add_cut(32'hFFFF_FFFF);
          default: add_cut($urandom);
        endcase
      end else begin
        add_noise();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, wraps, saturation, zero denominators
    add_cut(32'hFFFF_FFFF);
    add_cut(32'd0);
    add_timeout(32'hFFFF_FFF0);
    add_send(32'hFFFF_FFF0, 16'hFFFF, 32'd0);
    add_send(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_ack(32'hFFFF_FFF0, 32'hFFFF_FFF0 - 32'h7FFF_FFFF, 1'b1);
    add_ack(32'hFFFF_FFF0, 32'hFFFF_FFF0 - 32'h7FFF_FFFF, 1'b1);
    add_ack(32'hFFFF_FFF0, 32'hFFFF_FFF0 - 32'h7FFF_FFFF, 1'b0);
    add_ack(32'hFFFF_FFF1, 32'hFFFF_FFF0, 1'b1);
    add_timeout(32'd100);
    add_ack(32'd200, 32'd200, 1'b0);
    add_ack(32'h8000_0000, 32'd0, 1'b1);
    add_ack(32'hFFFF_FFFF, 32'd0, 1'b1);
    add_timeout(32'h7FFF_FFFF);
    add_send(32'h7FFF_FFFF, 16'd1, 32'h7FFF_FFFF);
    add_ack(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    add_cut(32'hFFFF_FFFF);
    add_cut(32'd1000);
    wait_drained();

    write_reg(REG_EWMA_WEIGHT, 17'd65536);
    write_reg(REG_SEGMENT_SIZE, 17'd65535);
    run_traffic(110);
    wait_drained();

    write_reg(REG_EWMA_WEIGHT, 17'd0);
    write_reg(REG_SEGMENT_SIZE, 17'd1);
    run_traffic(90);
    wait_drained();

    write_reg(REG_EWMA_WEIGHT, 17'h1FFFF);
    write_reg(REG_SEGMENT_SIZE, 17'd0);
    run_traffic(100);
    wait_drained();

    write_reg(REG_EWMA_WEIGHT, 17'd4096);
    write_reg(REG_SEGMENT_SIZE, 17'd1460);
    run_traffic(150);
    wait_drained();

    write_reg(REG_EWMA_WEIGHT, 17'($urandom_range(1, 65535)));
    write_reg(REG_SEGMENT_SIZE, 17'($urandom_range(1, 65535)));
    run_traffic(150);
    wait_drained();

    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
